// File: hdl/mfbc_pkg.sv
package mfbc_pkg;

	localparam int unsigned NUM_ROUNDS = 32;
	localparam int unsigned NUM_KEYS   = 8;
	localparam int unsigned KEY_IDX_W  = 3;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned ROT_LEFT   = 11;
	localparam int unsigned NIBBLES    = 8;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  req_type;
		word_t block_lo;
		word_t block_hi;
	} in_word_t;

	typedef struct packed {
		word_t result_lo;
		word_t result_hi;
	} out_word_t;

	typedef struct packed {
		logic  dec;
		word_t left;
		word_t right;
	} stage_t;

	localparam logic [3:0] SBOX_TAB [0:7][0:15] = '{
		'{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
		  4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
		'{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
		  4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
		'{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
		'{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
		  4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
		'{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
		  4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
		'{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
		  4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
		'{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
		  4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
		'{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
		  4'd4, 4'd10, 4'd9, 4'd15, 4'd11, 4'd6, 4'd2, 4'd12}
	};

	// Nibble p of the sum goes through box p XOR 1, so the high nibble of
	// byte b uses box 2b and the low nibble box 2b+1.
	function automatic word_t round_fn(input word_t half, input word_t key);
		word_t sum;
		word_t sub;
		sum = half + key;
		sub = '0;
		for (int p = 0; p < NIBBLES; p++) begin
			sub[4*p +: 4] = SBOX_TAB[p ^ 1][sum[4*p +: 4]];
		end
		return {sub[WORD_W-ROT_LEFT-1:0], sub[WORD_W-1:WORD_W-ROT_LEFT]};
	endfunction

endpackage

// File: hdl/mfbc_round_cell.sv
module mfbc_round_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  mfbc_pkg::stage_t up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output mfbc_pkg::stage_t dn_data,
	input  mfbc_pkg::word_t  enc_key,
	input  mfbc_pkg::word_t  dec_key
);
	import mfbc_pkg::*;

	logic   valid_q;
	stage_t data_q;
	stage_t next_data;
	word_t  key;

	assign up_ready = !valid_q || dn_ready;
	assign key      = up_data.dec ? dec_key : enc_key;

	always_comb begin
		next_data.dec   = up_data.dec;
		next_data.left  = up_data.right ^ round_fn(up_data.left, key);
		next_data.right = up_data.left;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= next_data;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

// File: hdl/magma_feistel_block_cipher.sv
// Channel   Direction  Handshake             Word
// in        input      in_valid / in_ready   in_data (req_type, block_lo, block_hi)
// out       output     out_valid / out_ready out_data (result_lo, result_hi)
// cfg       input      cfg_we                cfg_idx, cfg_data (key words 0 to 7)
//
// A word passes through a row of 32 round cells, one round per cell, each cell
// registering it in turn; one word can enter every cycle unless all cells stall.
// Each cell stalls only while it holds a word and the next cell cannot take it.
// Reset empties every cell and clears all key words to zero.
// Key words must only be written while no word is in flight.
module magma_feistel_block_cipher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  mfbc_pkg::in_word_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output mfbc_pkg::out_word_t             out_data,
	input  logic                            cfg_we,
	input  logic [mfbc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  mfbc_pkg::word_t                 cfg_data
);
	import mfbc_pkg::*;

	word_t                 key_q [NUM_KEYS];
	logic [NUM_ROUNDS:0]   vld;
	logic [NUM_ROUNDS:0]   rdy;
	stage_t                stage [NUM_ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_KEYS))) begin
			key_q[cfg_idx[KEY_IDX_W-1:0]] <= cfg_data;
		end
	end

	assign vld[0]         = in_valid;
	assign in_ready       = rdy[0];
	assign stage[0].dec   = in_data.req_type;
	assign stage[0].left  = in_data.block_lo;
	assign stage[0].right = in_data.block_hi;

	for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_cell
		localparam int unsigned EncIdx = r % NUM_KEYS;
		localparam int unsigned DecIdx = NUM_KEYS - 1 - (r % NUM_KEYS);

		mfbc_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[r]),
			.up_ready (rdy[r]),
			.up_data  (stage[r]),
			.dn_valid (vld[r+1]),
			.dn_ready (rdy[r+1]),
			.dn_data  (stage[r+1]),
			.enc_key  (key_q[EncIdx]),
			.dec_key  (key_q[DecIdx])
		);
	end

	assign out_valid          = vld[NUM_ROUNDS];
	assign rdy[NUM_ROUNDS]    = out_ready;
	assign out_data.result_lo = stage[NUM_ROUNDS].right;
	assign out_data.result_hi = stage[NUM_ROUNDS].left;

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (out_ready || !(&vld[NUM_ROUNDS:1])))
		else $error("input taken while every round cell is full and stalled");

	a_bad_index_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_idx >= CFG_IDX_W'(NUM_KEYS))) |=>
		($stable(key_q[0]) && $stable(key_q[1]) && $stable(key_q[2]) &&
		 $stable(key_q[3]) && $stable(key_q[4]) && $stable(key_q[5]) &&
		 $stable(key_q[6]) && $stable(key_q[7])))
		else $error("write beyond the key words changed a key");

	a_key_written: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_idx < CFG_IDX_W'(NUM_KEYS))) |=>
		(key_q[$past(cfg_idx[KEY_IDX_W-1:0])] == $past(cfg_data)))
		else $error("key word write was lost");

endmodule
